FILE: hw/rtl/tsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series partial sums - shared package
// Types and constants used by the front end, the queue and the series engine.
// ----------------------------------------------------------------------------
package tsps_pkg;

    localparam int XW = 32;

    typedef enum logic [1:0]
    {
        FN_SIN  = 2'd0,
        FN_COS  = 2'd1,
        FN_EXP  = 2'd2,
        FN_LN1P = 2'd3
    } func_t;

    // One classified request as it travels from front end to engine.
    typedef struct packed
    {
        func_t             func;
        logic              rev;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] ideal;
        logic [6:0]        n;
    } req_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SQ,
        ST_SQW,
        ST_INIT,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_STORE,
        ST_SUMRD,
        ST_SUMRDW,
        ST_SUM,
        ST_EMIT
    } eng_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tsps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series partial sums - front end
// Accepts requests, decodes the operation, clamps the term count, and keeps a
// two-entry queue towards the engine.
// ----------------------------------------------------------------------------
module tsps_front #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              op,
    input  wire logic signed [31:0]      x_arg,
    input  wire logic signed [31:0]      ideal,
    input  wire logic [5:0]              term_count_reg,
    output logic                         q_valid,
    input  wire logic                    q_pop,
    output tsps_pkg::req_t               q_req
);
    localparam int CAPN = (MAX_TERMS < 32) ? MAX_TERMS : 32;

    tsps_pkg::req_t slot_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    logic [6:0]     n_c;
    tsps_pkg::req_t new_req;
    logic           push;

    always_comb
    begin
        if (term_count_reg == 6'd0)
            n_c = 7'd1;
        else if ({1'b0, term_count_reg} > 7'(CAPN))
            n_c = 7'(CAPN);
        else
            n_c = {1'b0, term_count_reg};
        new_req.func  = tsps_pkg::func_t'(op[2:1]);
        new_req.rev   = op[0];
        new_req.x     = x_arg;
        new_req.ideal = ideal;
        new_req.n     = n_c;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= new_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tsps_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series partial sums - series engine
// Forms the terms with one shared registered multiplier, stores them, then
// sums forward or backward and hands each result word to an output register.
// ----------------------------------------------------------------------------
module tsps_engine #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire tsps_pkg::req_t       q_req,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [4:0]                term_index,
    output logic signed [31:0]        partial_sum,
    output logic [30:0]               abs_error,
    output logic                      last
);
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [63:0] ONE_U = 64'd1 << FRAC_BITS;
    localparam logic signed [31:0] ONE =
        (ONE_U > 64'd2147483647) ? 32'sh7fffffff : 32'(ONE_U);

    typedef logic [127:0][31:0] rtab_t;

    // Reciprocal table of 1/k for k up to 2*32+1, rounded half up. It is
    // worked out once at elaboration by shift-and-subtract long division.
    function automatic rtab_t gen_rtab();
        rtab_t       t;
        logic [63:0] num;
        logic [63:0] kk;
        logic [63:0] q;
        logic [64:0] rem;
        t = '0;
        for (int j = 0; j < 66; j++)
        begin
            kk  = (j == 0) ? 64'd1 : 64'(j);
            num = ONE_U + (kk >> 1);
            q   = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[63:0], num[b]};
                q   = q << 1;
                if (rem >= {1'b0, kk})
                begin
                    rem  = rem - {1'b0, kk};
                    q[0] = 1'b1;
                end
            end
            t[j] = (q > 64'd2147483647) ? 32'h7fffffff : q[31:0];
        end
        return t;
    endfunction

    localparam rtab_t RTAB = gen_rtab();

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > SMAX)
            return 32'sh7fffffff;
        else if (v < SMIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Registered product; a half is added before the arithmetic shift, so it rounds half up.
    logic signed [31:0] ma_c, mb_c;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mres;
    always_ff @(posedge clk)
        prod_reg <= 64'(ma_c) * 64'(mb_c) + HALF;
    assign mres = sat(prod_reg >>> FRAC_BITS);

    tsps_pkg::eng_state_t st_reg, st_next;
    tsps_pkg::req_t  req_reg;
    logic signed [31:0] pw_reg, pw_next;
    logic signed [31:0] nx2_reg, nx2_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] sum_reg, sum_next;
    logic [6:0]  i_reg, i_next;
    logic signed [31:0] store_reg [MAX_TERMS];
    logic signed [31:0] rd_reg;
    logic        we;
    logic [6:0]  ra_c;
    logic [4:0]  ix_next;
    logic signed [31:0] nx;

    localparam int AW = $clog2(MAX_TERMS);

    always_ff @(posedge clk)
    begin
        if (we)
            store_reg[i_reg[AW-1:0]] <= t_reg;
        rd_reg <= store_reg[ra_c[AW-1:0]];
    end

    assign nx = sat(-64'(req_reg.x));

    logic signed [63:0] dsum, derr;
    always_comb
    begin
        dsum = 64'(sum_reg) + 64'(rd_reg);
        derr = 64'(sat(dsum)) - 64'(req_reg.ideal);
        if (derr < 0)
            derr = -derr;
    end

    logic ov_next;
    logic [4:0] oi_next;
    logic signed [31:0] os_next;
    logic [30:0] oe_next;
    logic ol_next;

    always_comb
    begin
        st_next  = st_reg;
        pw_next  = pw_reg;
        nx2_next = nx2_reg;
        t_next   = t_reg;
        sum_next = sum_reg;
        i_next   = i_reg;
        q_pop    = 1'b0;
        we       = 1'b0;
        ma_c     = pw_reg;
        mb_c     = nx2_reg;
        ov_next  = out_valid;
        oi_next  = term_index;
        os_next  = partial_sum;
        oe_next  = abs_error;
        ol_next  = last;
        ra_c     = req_reg.rev ? i_reg - 7'd1 : i_reg;
        ix_next  = ra_c[4:0];
        if (out_valid && !out_stall)
            ov_next = 1'b0;
        case (st_reg)
            tsps_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    st_next = tsps_pkg::ST_SQ;
                end
            end
            tsps_pkg::ST_SQ:
            begin
                ma_c = req_reg.x;
                mb_c = req_reg.x;
                st_next = tsps_pkg::ST_SQW;
            end
            tsps_pkg::ST_SQW:
            begin
                nx2_next = sat(-64'(mres));
                st_next  = tsps_pkg::ST_INIT;
            end
            tsps_pkg::ST_INIT:
            begin
                i_next = 7'd0;
                pw_next = (req_reg.func == tsps_pkg::FN_SIN ||
                           req_reg.func == tsps_pkg::FN_LN1P) ? req_reg.x : ONE;
                t_next = (req_reg.func == tsps_pkg::FN_SIN ||
                          req_reg.func == tsps_pkg::FN_LN1P) ? req_reg.x : ONE;
                st_next = tsps_pkg::ST_STORE;
            end
            // Multiply chain of one term: first by x, -x or -x*x.
            tsps_pkg::ST_M1:
            begin
                ma_c = pw_reg;
                case (req_reg.func)
                    tsps_pkg::FN_EXP:  mb_c = req_reg.x;
                    tsps_pkg::FN_LN1P: mb_c = nx;
                    default:           mb_c = nx2_reg;
                endcase
                st_next = tsps_pkg::ST_M2;
            end
            tsps_pkg::ST_M2:
            begin
                ma_c = mres;
                case (req_reg.func)
                    tsps_pkg::FN_SIN:  mb_c = RTAB[7'(i_reg << 1)];
                    tsps_pkg::FN_COS:  mb_c = RTAB[7'((i_reg << 1) - 7'd1)];
                    tsps_pkg::FN_EXP:  mb_c = RTAB[i_reg];
                    default:           mb_c = RTAB[7'(i_reg + 7'd1)];
                endcase
                if (req_reg.func == tsps_pkg::FN_LN1P)
                    pw_next = mres;
                st_next = tsps_pkg::ST_M3;
            end
            tsps_pkg::ST_M3:
            begin
                ma_c = mres;
                mb_c = (req_reg.func == tsps_pkg::FN_SIN) ?
                       RTAB[7'((i_reg << 1) + 7'd1)] : RTAB[7'(i_reg << 1)];
                case (req_reg.func)
                    tsps_pkg::FN_SIN, tsps_pkg::FN_COS:
                        st_next = tsps_pkg::ST_M3;
                    default:
                    begin
                        t_next = mres;
                        if (req_reg.func == tsps_pkg::FN_EXP)
                            pw_next = mres;
                        st_next = tsps_pkg::ST_STORE;
                    end
                endcase
                if (req_reg.func == tsps_pkg::FN_SIN ||
                    req_reg.func == tsps_pkg::FN_COS)
                    st_next = tsps_pkg::ST_SUMRDW;
            end
            // Extra state for the trigonometric third product.
            tsps_pkg::ST_SUMRDW:
            begin
                if (i_reg == req_reg.n)
                begin
                    sum_next = dsum[31:0];
                    st_next  = tsps_pkg::ST_SUM;
                end
                else
                begin
                    t_next  = mres;
                    pw_next = mres;
                    st_next = tsps_pkg::ST_STORE;
                end
            end
            tsps_pkg::ST_STORE:
            begin
                we = 1'b1;
                if (i_reg + 7'd1 == req_reg.n)
                begin
                    sum_next = '0;
                    i_next   = req_reg.rev ? req_reg.n : 7'd0;
                    st_next  = tsps_pkg::ST_SUMRD;
                end
                else
                begin
                    i_next  = i_reg + 7'd1;
                    st_next = tsps_pkg::ST_M1;
                end
            end
            tsps_pkg::ST_SUMRD:
                st_next = tsps_pkg::ST_SUM;
            tsps_pkg::ST_SUM:
            begin
                if (!out_valid || !out_stall)
                begin
                    ov_next  = 1'b1;
                    oi_next  = ix_next;
                    os_next  = sat(dsum);
                    oe_next  = (derr > SMAX) ? 31'h7fffffff : derr[30:0];
                    sum_next = sat(dsum);
                    ol_next  = req_reg.rev ? (i_reg == 7'd1)
                                           : (i_reg + 7'd1 == req_reg.n);
                    if (ol_next)
                        st_next = tsps_pkg::ST_IDLE;
                    else
                    begin
                        i_next  = req_reg.rev ? i_reg - 7'd1 : i_reg + 7'd1;
                        st_next = tsps_pkg::ST_EMIT;
                    end
                end
            end
            tsps_pkg::ST_EMIT:
                st_next = tsps_pkg::ST_SUM;
            default:
                st_next = tsps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            req_reg <= q_req;
        pw_reg   <= pw_next;
        nx2_reg  <= nx2_next;
        t_reg    <= t_next;
        sum_reg  <= sum_next;
        i_reg    <= i_next;
        term_index  <= oi_next;
        partial_sum <= os_next;
        abs_error   <= oe_next;
        last        <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= tsps_pkg::ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            out_valid <= ov_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/taylor_series_partial_sums.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series partial sums - top level
// Maclaurin series of sin, cos, exp and ln(1+x) with a result word per term.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    op, x_arg, ideal
//  out      source     out_valid/out_stall  term_index, partial_sum, abs_error, last
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (term_count)
//
// From its pop, a request forms its n terms through the one shared multiplier,
// stores them, then emits one result word per term as they are summed.
// Reset clears control state only; no clearing pass is needed.
// A stalled output holds the engine; the front queue keeps two requests.
module taylor_series_partial_sums #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 28
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] x_arg,
    input  wire logic signed [31:0] ideal,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [4:0]              term_index,
    output logic signed [31:0]      partial_sum,
    output logic [30:0]             abs_error,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data
);
    logic [5:0]     term_count_reg;
    logic           q_valid;
    logic           q_pop;
    tsps_pkg::req_t q_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_count_reg <= 6'd20;
        else if (cfg_valid)
            term_count_reg <= cfg_data;
    end

    tsps_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .x_arg(x_arg), .ideal(ideal), .term_count_reg(term_count_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    tsps_engine #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_req(q_req), .out_valid(out_valid), .out_stall(out_stall),
        .term_index(term_index), .partial_sum(partial_sum),
        .abs_error(abs_error), .last(last)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/tsps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series partial sums - port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module tsps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  term_index,
    input wire logic [31:0] partial_sum,
    input wire logic [30:0] abs_error,
    input wire logic        last
);
    // A stalled output word must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable({term_index, partial_sum, abs_error, last}))
        else $error("stalled output changed");

    // A word on offer carries no unknown bits.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({term_index, partial_sum, abs_error, last}))
        else $error("unknown output word");

    // Handshake outputs out_valid and in_stall are always driven once out of reset.
    a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({out_valid, in_stall}))
        else $error("unknown handshake output");
endmodule

bind taylor_series_partial_sums tsps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .term_index(term_index), .partial_sum(partial_sum),
    .abs_error(abs_error), .last(last)
);
`default_nettype wire

FILE: test/taylor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor series partial sums - result checker
// Watches the request, result and term count channels, works out the partial
// sums that each accepted request must produce and compares every result word
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module taylor_checker #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] x_arg,
    input  logic signed [31:0] ideal,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [4:0]         term_index,
    input  logic signed [31:0] partial_sum,
    input  logic [30:0]        abs_error,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [5:0]         cfg_data,
    output int                 errors,
    output int                 sums_owed
);

    typedef struct packed
    {
        logic [4:0]         idx;
        logic signed [31:0] sum;
        logic [30:0]        err;
        logic               fin;
    } partial_t;

    partial_t   owed_sums[$];
    logic [5:0] term_count;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Product rounded half up at the binary point, then saturated.
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return sat32(p >>> FRAC_BITS);
    endfunction

    function automatic longint recip(int k);
        longint r;
        r = ((64'sd1 <<< FRAC_BITS) + k / 2) / k;
        return (r > 64'sd2147483647) ? 64'sd2147483647 : r;
    endfunction

    task automatic predict_sums(logic [2:0] opc, longint x, longint ref_val);
        longint          terms[MAX_TERMS];
        longint          pw;
        longint          one;
        longint          negx;
        longint          negx2;
        longint          acc;
        longint          d;
        int              n;
        int              j;
        tsps_pkg::func_t fn;
        partial_t        p;
        fn    = tsps_pkg::func_t'(opc[2:1]);
        n     = term_count;
        one   = sat32(64'sd1 <<< FRAC_BITS);
        negx  = sat32(-x);
        negx2 = sat32(-fx_mul(x, x));
        pw    = 0;
        if (n < 1)
            n = 1;
        if (n > MAX_TERMS)
            n = MAX_TERMS;
        if (n > 32)
            n = 32;
        for (int i = 0; i < n; i++)
        begin
            case (fn)
                tsps_pkg::FN_SIN:
                    pw = (i == 0) ? x : fx_mul(fx_mul(fx_mul(pw, negx2),
                        recip(2 * i)), recip(2 * i + 1));
                tsps_pkg::FN_COS:
                    pw = (i == 0) ? one : fx_mul(fx_mul(fx_mul(pw, negx2),
                        recip(2 * i - 1)), recip(2 * i));
                tsps_pkg::FN_EXP:
                    pw = (i == 0) ? one : fx_mul(fx_mul(pw, x), recip(i));
                default:
                    pw = (i == 0) ? x : fx_mul(pw, negx);
            endcase
            terms[i] = (fn == tsps_pkg::FN_LN1P) ? fx_mul(pw, recip(i + 1)) : pw;
        end
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            // Reverse summation walks the stored terms from the top index down.
            j   = opc[0] ? n - 1 - i : i;
            acc = sat32(acc + terms[j]);
            d   = acc - ref_val;
            if (d < 0)
                d = -d;
            if (d > 64'sd2147483647)
                d = 64'sd2147483647;
            p.idx = j[4:0];
            p.sum = acc[31:0];
            p.err = d[30:0];
            p.fin = (i == n - 1);
            owed_sums.push_back(p);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        partial_t e;
        if (!rst_n)
        begin
            term_count = 6'd20;
            errors     = 0;
            owed_sums.delete();
            sums_owed  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                term_count = cfg_data;
            if (in_valid && !in_stall)
                predict_sums(op, longint'(x_arg), longint'(ideal));
            if (out_valid && !out_stall)
            begin
                if (owed_sums.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result word with none owed: idx %0d sum %h",
                            $realtime, term_index, partial_sum);
                end
                else
                begin
                    e = owed_sums.pop_front();
                    if (e.idx !== term_index || e.sum !== partial_sum
                        || e.err !== abs_error || e.fin !== last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp idx %0d sum %h err %h ",
                                "last %b, got idx %0d sum %h err %h last %b"},
                                $realtime, e.idx, e.sum, e.err, e.fin,
                                term_index, partial_sum, abs_error, last);
                    end
                end
            end
            sums_owed = owed_sums.size();
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor series partial sums - testbench top
// Drives requests and term count writes with random gaps and output stalls;
// the checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         op = '0;
    logic signed [31:0] x_arg = '0;
    logic signed [31:0] ideal = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [4:0]         term_index;
    logic signed [31:0] partial_sum;
    logic [30:0]        abs_error;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [5:0]         cfg_data = '0;
    int                 errors;
    int                 sums_owed;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;
    logic               word_taken = 1'b0;
    logic               no_gaps = 1'b0;

    always #5 clk = ~clk;

    taylor_series_partial_sums dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .x_arg(x_arg), .ideal(ideal),
        .out_valid(out_valid), .out_stall(out_stall),
        .term_index(term_index), .partial_sum(partial_sum),
        .abs_error(abs_error), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    taylor_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .x_arg(x_arg), .ideal(ideal),
        .out_valid(out_valid), .out_stall(out_stall),
        .term_index(term_index), .partial_sum(partial_sum),
        .abs_error(abs_error), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .sums_owed(sums_owed)
    );

    // The receiver draws a fresh wait before each word it takes.
    always @(posedge clk)
        word_taken <= out_valid && !out_stall;

    always @(negedge clk)
    begin
        if (word_taken)
            stall_left = no_gaps ? 0 : $urandom_range(0, 13);
        out_stall = (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] opc, logic [31:0] x, logic [31:0] r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        op       = opc;
        x_arg    = x;
        ideal    = r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_term_count(logic [5:0] v);
        // Withdraw the last request, then let every owed word drain so the
        // block is idle.
        @(negedge clk);
        in_valid = 1'b0;
        while (sums_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_arg();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        // Mostly within two in magnitude, where sin, cos and exp converge.
        return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
    endfunction

    initial
    begin
        logic [5:0]  counts[8];
        logic [31:0] xr;
        counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd20, 6'd0, 6'd0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset term count.
        for (int k = 0; k < 8; k++)
            send_request(k[2:0], 32'h0800_0000, 32'h0);
        send_request({tsps_pkg::FN_SIN, 1'b0}, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request({tsps_pkg::FN_COS, 1'b1}, 32'h8000_0000, 32'h8000_0000);
        send_request({tsps_pkg::FN_EXP, 1'b0}, 32'h7fff_ffff, 32'h8000_0000);
        send_request({tsps_pkg::FN_EXP, 1'b1}, 32'h8000_0000, 32'h7fff_ffff);
        send_request({tsps_pkg::FN_LN1P, 1'b0}, 32'h7fff_ffff, 32'h0);
        send_request({tsps_pkg::FN_LN1P, 1'b1}, 32'h8000_0000, 32'h1);
        send_request({tsps_pkg::FN_SIN, 1'b1}, 32'h0, 32'hffff_ffff);
        send_request({tsps_pkg::FN_COS, 1'b0}, 32'hffff_ffff, 32'h1000_0000);
        send_request({tsps_pkg::FN_EXP, 1'b0}, 32'h1, 32'h0);
        send_request({tsps_pkg::FN_LN1P, 1'b0}, 32'hf000_0001, 32'h5555_5555);

        counts[6] = 6'($urandom_range(2, 31));
        counts[7] = 6'($urandom_range(0, 63));
        for (int ph = 0; ph < 8; ph++)
        begin
            write_term_count(counts[ph]);
            no_gaps = (ph == 2 || ph == 5);
            for (int k = 0; k < 52; k++)
            begin
                xr = pick_arg();
                send_request(3'($urandom_range(0, 7)), xr,
                    ($urandom_range(0, 2) == 0) ? $urandom : xr);
            end
        end
        @(negedge clk);
        in_valid = 1'b0;
        no_gaps  = 1'b0;

        while (sums_owed != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
